@@ hw/rtl/fms_pkg.sv @@
// Package with the shared types, codes and constants of the flight mode supervisor.
package fms_pkg;

    // Flight mode codes.
    localparam logic [2:0] FM_DISARM   = 3'd0;
    localparam logic [2:0] FM_ATTITUDE = 3'd1;
    localparam logic [2:0] FM_POS_JOY  = 3'd2;
    localparam logic [2:0] FM_POS_EXT  = 3'd3;
    localparam logic [2:0] FM_AUTOLAND = 3'd4;

    // Controller codes.
    localparam logic CTRL_LOCAL   = 1'b0;
    localparam logic CTRL_ONBOARD = 1'b1;

    // Button bit positions.
    localparam int BTN_A      = 0;
    localparam int BTN_B      = 1;
    localparam int BTN_X      = 2;
    localparam int BTN_Y      = 3;
    localparam int BTN_START  = 4;
    localparam int BTN_LEFT   = 5;
    localparam int BTN_RIGHT  = 6;
    localparam int BTN_SELECT = 7;

    // Trigger bit positions.
    localparam int TRG_DISARM    = 0;
    localparam int TRG_POS_EXT   = 1;
    localparam int TRG_POS_JOY   = 2;
    localparam int TRG_LAND      = 3;
    localparam int TRG_ONBOARD   = 4;
    localparam int TRG_LOCAL     = 5;

    // Reset value of the retry interval register.
    localparam logic [7:0] RETRY_TICKS_RESET = 8'd20;
    localparam logic [7:0] TICKS_MAX         = 8'hFF;

    // One supervisor tick as it enters the logic.
    typedef struct packed {
        logic [7:0] button_mask;
        logic [5:0] trigger_mask;
        logic       odom_stale;
        logic       joy_stale;
        logic       offboard_active;
        logic       vehicle_armed;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [2:0] flight_mode;
        logic       controller_select;
        logic       reference_frame;
        logic       request_offboard;
        logic       request_arm;
        logic       request_disarm;
        logic       halted;
    } t_result;

    // Supervisor state carried from tick to tick.
    typedef struct packed {
        logic [2:0] mode;
        logic       controller;
        logic       frame;
        logic [7:0] ticks;
        logic       disarm_pending;
        logic       terminate_pending;
        logic       halted;
    } t_state;

endpackage

@@ hw/rtl/fms_if.sv @@
// Handshake interfaces for the tick input, result output and configuration write channels.
interface fms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] button_mask;
    logic [5:0] trigger_mask;
    logic       odom_stale;
    logic       joy_stale;
    logic       offboard_active;
    logic       vehicle_armed;

    modport source (output valid, button_mask, trigger_mask, odom_stale, joy_stale,
                    offboard_active, vehicle_armed, input ready);
    modport sink   (input valid, button_mask, trigger_mask, odom_stale, joy_stale,
                    offboard_active, vehicle_armed, output ready);
endinterface

interface fms_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] flight_mode;
    logic       controller_select;
    logic       reference_frame;
    logic       request_offboard;
    logic       request_arm;
    logic       request_disarm;
    logic       halted;

    modport source (output valid, flight_mode, controller_select, reference_frame,
                    request_offboard, request_arm, request_disarm, halted, input ready);
    modport sink   (input valid, flight_mode, controller_select, reference_frame,
                    request_offboard, request_arm, request_disarm, halted, output ready);
endinterface

interface fms_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/flight_mode_supervisor.sv @@
// Flight mode supervisor: input register, tick logic, state and result register.
// A tick beat is held in the input register, and its result then in the result register.
// Throughput: one tick per cycle while the result can move on, set by the combinational tick logic and state update.
// The input register takes a new beat while a result waits if it is empty or the result can move on.
// Synchronous active-low reset clears mode, controller, frame, counter and flags to zero,
// empties both registers and sets the retry interval to 20 ticks.
module flight_mode_supervisor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fms_in_if.sink     i_item,
    fms_out_if.source  o_result,
    fms_cfg_if.sink    i_cfg
);

    logic              r_in_valid;
    fms_pkg::t_item    r_in;
    logic              r_out_valid;
    fms_pkg::t_result  r_out;
    fms_pkg::t_state   r_state;
    logic [7:0]        r_retry_ticks;

    fms_pkg::t_item    item_beat;
    fms_pkg::t_state   n_state;
    fms_pkg::t_result  n_out;
    logic              advance;

    // The input register moves on when the result register is free or being emptied.
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    assign item_beat.button_mask     = i_item.button_mask;
    assign item_beat.trigger_mask    = i_item.trigger_mask;
    assign item_beat.odom_stale      = i_item.odom_stale;
    assign item_beat.joy_stale       = i_item.joy_stale;
    assign item_beat.offboard_active = i_item.offboard_active;
    assign item_beat.vehicle_armed   = i_item.vehicle_armed;

    fms_tick u_tick (
        .i_state       (r_state),
        .i_item        (r_in),
        .i_retry_ticks (r_retry_ticks),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // Control state, supervisor state and the retry interval register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
            r_retry_ticks <= fms_pkg::RETRY_TICKS_RESET;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_retry_ticks <= i_cfg.data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= item_beat;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.flight_mode       = r_out.flight_mode;
    assign o_result.controller_select = r_out.controller_select;
    assign o_result.reference_frame   = r_out.reference_frame;
    assign o_result.request_offboard  = r_out.request_offboard;
    assign o_result.request_arm       = r_out.request_arm;
    assign o_result.request_disarm    = r_out.request_disarm;
    assign o_result.halted            = r_out.halted;

endmodule

@@ hw/rtl/fms_tick.sv @@
// Combinational tick logic: applies one tick's events to the state and forms the requests.
module fms_tick (
    input  fms_pkg::t_state  i_state,
    input  fms_pkg::t_item   i_item,
    input  logic [7:0]       i_retry_ticks,
    output fms_pkg::t_state  o_state,
    output fms_pkg::t_result o_result
);

    always_comb begin
        fms_pkg::t_state s;
        logic            pos_ok;
        logic [7:0]      elapsed;
        logic            allowed;
        logic            req_off;
        logic            req_arm;
        logic            req_dis;

        s       = i_state;
        req_off = 1'b0;
        req_arm = 1'b0;
        req_dis = 1'b0;
        pos_ok  = !i_item.odom_stale && !i_item.joy_stale;
        elapsed = (i_state.ticks == fms_pkg::TICKS_MAX) ? fms_pkg::TICKS_MAX
                                                         : i_state.ticks + 8'd1;
        allowed = elapsed >= i_retry_ticks;

        if (i_state.halted) begin
            // Halted: every input is ignored.
        end else if (i_state.terminate_pending) begin
            // Final tick after a terminate: one last disarm, then halt.
            req_dis             = 1'b1;
            s.halted            = 1'b1;
            s.terminate_pending = 1'b0;
            s.disarm_pending    = 1'b0;
        end else begin
            // Joystick buttons, in rising priority: a later button overrides an earlier one.
            if (i_item.button_mask[fms_pkg::BTN_A]) begin
                s.mode = fms_pkg::FM_DISARM;
            end
            if (i_item.button_mask[fms_pkg::BTN_B] && pos_ok) begin
                s.mode = fms_pkg::FM_POS_EXT;
            end
            if (i_item.button_mask[fms_pkg::BTN_X] && pos_ok) begin
                s.mode = fms_pkg::FM_POS_JOY;
            end
            if (i_item.button_mask[fms_pkg::BTN_Y]) begin
                s.mode = fms_pkg::FM_ATTITUDE;
            end
            if (i_item.button_mask[fms_pkg::BTN_START]) begin
                s.mode = fms_pkg::FM_AUTOLAND;
            end
            // Selecting the controller that is already active toggles the frame.
            if (i_item.button_mask[fms_pkg::BTN_LEFT]) begin
                if (s.controller == fms_pkg::CTRL_LOCAL) begin
                    s.frame = ~s.frame;
                end
                s.controller = fms_pkg::CTRL_LOCAL;
            end
            if (i_item.button_mask[fms_pkg::BTN_RIGHT]) begin
                if (s.controller == fms_pkg::CTRL_ONBOARD) begin
                    s.frame = ~s.frame;
                end
                s.controller = fms_pkg::CTRL_ONBOARD;
            end
            if (i_item.button_mask[fms_pkg::BTN_SELECT]) begin
                s.terminate_pending = 1'b1;
            end

            // Trigger events; a queued disarm acts like the disarm trigger.
            if (i_item.trigger_mask[fms_pkg::TRG_DISARM] || i_state.disarm_pending) begin
                s.mode = fms_pkg::FM_DISARM;
            end
            s.disarm_pending = 1'b0;
            if (i_item.trigger_mask[fms_pkg::TRG_POS_EXT] && pos_ok) begin
                s.mode = fms_pkg::FM_POS_EXT;
            end
            if (i_item.trigger_mask[fms_pkg::TRG_POS_JOY] && pos_ok) begin
                s.mode = fms_pkg::FM_POS_JOY;
            end
            if (i_item.trigger_mask[fms_pkg::TRG_LAND]) begin
                s.mode = fms_pkg::FM_AUTOLAND;
            end
            if (i_item.trigger_mask[fms_pkg::TRG_ONBOARD]) begin
                s.controller = fms_pkg::CTRL_ONBOARD;
            end
            if (i_item.trigger_mask[fms_pkg::TRG_LOCAL]) begin
                s.controller = fms_pkg::CTRL_LOCAL;
            end

            // Requests, with offboard and arm rate-limited by the tick counter.
            s.ticks = elapsed;
            if (s.mode >= fms_pkg::FM_ATTITUDE && s.mode <= fms_pkg::FM_AUTOLAND) begin
                if (!i_item.offboard_active && allowed) begin
                    req_off = 1'b1;
                    s.ticks = '0;
                end else if (s.mode == fms_pkg::FM_AUTOLAND && !i_item.vehicle_armed) begin
                    s.disarm_pending = 1'b1;
                end else if (!i_item.vehicle_armed && allowed) begin
                    req_arm = 1'b1;
                    s.ticks = '0;
                end
            end else begin
                req_dis = 1'b1;
            end
        end

        o_state                    = s;
        o_result.flight_mode       = s.mode;
        o_result.controller_select = s.controller;
        o_result.reference_frame   = s.frame;
        o_result.request_offboard  = req_off;
        o_result.request_arm       = req_arm;
        o_result.request_disarm    = req_dis;
        o_result.halted            = s.halted;
    end

endmodule
